### rtl/core/packed_pixel_format_unpacker_assert.svh
// assertion macros for the packed pixel format unpacker
`ifndef PACKED_PIXEL_FORMAT_UNPACKER_ASSERT_SVH
`define PACKED_PIXEL_FORMAT_UNPACKER_ASSERT_SVH

// same-cycle implication
`define PPFU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPFU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ppfu_pkg.sv
// shared types, format codes and unpack functions for the pixel unpacker
`timescale 1ns / 1ps
`default_nettype none
package ppfu_pkg;

   localparam int GroupBytes = 12;
   localparam int CsrWidth   = 16;

   localparam logic [3:0] FMT_YUYV8  = 4'd0;
   localparam logic [3:0] FMT_YUYV16 = 4'd1;
   localparam logic [3:0] FMT_UYYVYY = 4'd2;
   localparam logic [3:0] FMT_YUV41P = 4'd3;
   localparam logic [3:0] FMT_BGR15  = 4'd4;
   localparam logic [3:0] FMT_BGR15X = 4'd5;
   localparam logic [3:0] FMT_BGR16  = 4'd6;
   localparam logic [3:0] FMT_BGR16X = 4'd7;
   localparam logic [3:0] FMT_RGB24  = 4'd8;
   localparam logic [3:0] FMT_ARGB32 = 4'd9;
   localparam logic [3:0] FMT_BGRA32 = 4'd10;
   localparam logic [3:0] FMT_RGB48  = 4'd11;
   localparam logic [3:0] FMT_RGB30  = 4'd12;
   localparam logic [3:0] FMT_MONO12 = 4'd13;

   localparam logic [2:0] CSR_FORMAT      = 3'd0;
   localparam logic [2:0] CSR_LUMA_OFFSET = 3'd1;
   localparam logic [2:0] CSR_RED_PLANE   = 3'd2;
   localparam logic [2:0] CSR_GREEN_PLANE = 3'd3;
   localparam logic [2:0] CSR_BLUE_PLANE  = 3'd4;
   localparam logic [2:0] CSR_BYTE_SWAP   = 3'd5;
   localparam logic [2:0] CSR_SAMPLE_MASK = 3'd6;

   localparam logic [1:0] PLANE_NONE = 2'd3;

   typedef logic [GroupBytes-1:0][7:0] group_type;

   typedef struct packed {
      logic [3:0]  format;
      logic        luma_offset;
      logic [1:0]  red_plane;
      logic [1:0]  green_plane;
      logic [1:0]  blue_plane;
      logic        byte_swap;
      logic [15:0] sample_mask;
   } unpack_cfg_type;

   typedef struct packed {
      logic [15:0] chan0;
      logic [15:0] chan1;
      logic [15:0] chan2;
   } pixel_type;

   function automatic logic [3:0] fmt_group_size(input logic [3:0] fmt);
      logic [3:0] size;
      case (fmt)
         FMT_YUYV8:  size = 4'd4;
         FMT_YUYV16: size = 4'd8;
         FMT_UYYVYY: size = 4'd6;
         FMT_YUV41P: size = 4'd12;
         FMT_BGR15, FMT_BGR15X, FMT_BGR16, FMT_BGR16X: size = 4'd2;
         FMT_RGB24:  size = 4'd3;
         FMT_ARGB32, FMT_BGRA32, FMT_RGB30: size = 4'd4;
         FMT_RGB48:  size = 4'd6;
         FMT_MONO12: size = 4'd3;
         default:    size = 4'd0;
      endcase
      return size;
   endfunction

   // pixels per group, minus one
   function automatic logic [2:0] fmt_last_pixel(input logic [3:0] fmt);
      logic [2:0] n;
      case (fmt)
         FMT_YUYV8, FMT_YUYV16, FMT_MONO12: n = 3'd1;
         FMT_UYYVYY: n = 3'd3;
         FMT_YUV41P: n = 3'd7;
         default:    n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic pixel_type set_plane(input pixel_type pix, input logic [1:0] plane,
                                           input logic [15:0] val);
      pixel_type r;
      r = pix;
      case (plane)
         2'd0:    r.chan0 = val;
         2'd1:    r.chan1 = val;
         2'd2:    r.chan2 = val;
         default: r = pix;
      endcase
      return r;
   endfunction

   function automatic pixel_type map_planes(input unpack_cfg_type cfg, input logic [15:0] s0,
                                            input logic [15:0] s1, input logic [15:0] s2);
      pixel_type r;
      r = '0;
      r = set_plane(r, cfg.red_plane, s0);
      r = set_plane(r, cfg.green_plane, s1);
      r = set_plane(r, cfg.blue_plane, s2);
      return r;
   endfunction

   function automatic logic [15:0] word16(input group_type b, input logic [3:0] i);
      return {b[i + 4'd1], b[i]};
   endfunction

   function automatic logic [15:0] rgb48_sample(input unpack_cfg_type cfg, input group_type b,
                                                input logic [3:0] i);
      logic [15:0] w;
      w = cfg.byte_swap ? {b[i], b[i + 4'd1]} : {b[i + 4'd1], b[i]};
      return w & cfg.sample_mask;
   endfunction

   function automatic pixel_type unpack_pixel(input unpack_cfg_type cfg, input logic [2:0] k,
                                              input group_type b);
      pixel_type  r;
      logic       yo;
      logic [31:0] w;
      r  = '0;
      yo = cfg.luma_offset;
      w  = {b[3], b[2], b[1], b[0]};
      case (cfg.format)
         FMT_YUYV8: begin
            r.chan0 = 16'(k[0] ? (yo ? b[3] : b[2]) : (yo ? b[1] : b[0]));
            r.chan1 = 16'(yo ? b[0] : b[1]);
            r.chan2 = 16'(yo ? b[2] : b[3]);
         end
         FMT_YUYV16: begin
            r.chan0 = k[0] ? (yo ? word16(b, 4'd6) : word16(b, 4'd4))
                           : (yo ? word16(b, 4'd2) : word16(b, 4'd0));
            r.chan1 = yo ? word16(b, 4'd0) : word16(b, 4'd2);
            r.chan2 = yo ? word16(b, 4'd4) : word16(b, 4'd6);
         end
         FMT_UYYVYY: begin
            case (k[1:0])
               2'd0:    r.chan0 = 16'(b[1]);
               2'd1:    r.chan0 = 16'(b[2]);
               2'd2:    r.chan0 = 16'(b[4]);
               default: r.chan0 = 16'(b[5]);
            endcase
            r.chan1 = 16'(b[0]);
            r.chan2 = 16'(b[3]);
         end
         FMT_YUV41P: begin
            if (k[2]) begin
               r.chan0 = 16'(b[{2'b10, k[1:0]}]);
               r.chan1 = 16'(b[4]);
               r.chan2 = 16'(b[6]);
            end else begin
               r.chan0 = 16'(b[{1'b0, k[1:0], 1'b1}]);
               r.chan1 = 16'(b[0]);
               r.chan2 = 16'(b[2]);
            end
         end
         FMT_BGR15: begin
            r.chan0 = 16'({b[1][6:2], 3'b000});
            r.chan1 = 16'({b[1][1:0], b[0][7:5], 3'b000});
            r.chan2 = 16'({b[0][4:0], 3'b000});
         end
         FMT_BGR15X: begin
            r.chan0 = 16'({b[0][6:2], 3'b000});
            r.chan1 = 16'({b[0][1:0], b[1][7:5], 3'b000});
            r.chan2 = 16'({b[1][4:0], 3'b000});
         end
         FMT_BGR16: begin
            r.chan0 = 16'({b[1][7:3], 3'b000});
            r.chan1 = 16'({b[1][2:0], b[0][7:5], 2'b00});
            r.chan2 = 16'({b[0][4:0], 3'b000});
         end
         FMT_BGR16X: begin
            r.chan0 = 16'({b[0][7:3], 3'b000});
            r.chan1 = 16'({b[0][2:0], b[1][7:5], 2'b00});
            r.chan2 = 16'({b[1][4:0], 3'b000});
         end
         FMT_RGB24: r = map_planes(cfg, 16'(b[0]), 16'(b[1]), 16'(b[2]));
         FMT_ARGB32: begin
            r.chan0 = 16'(b[1]);
            r.chan1 = 16'(b[2]);
            r.chan2 = 16'(b[3]);
         end
         FMT_BGRA32: begin
            r.chan0 = 16'(b[2]);
            r.chan1 = 16'(b[1]);
            r.chan2 = 16'(b[0]);
         end
         FMT_RGB48: r = map_planes(cfg, rgb48_sample(cfg, b, 4'd0), rgb48_sample(cfg, b, 4'd2),
                                   rgb48_sample(cfg, b, 4'd4));
         FMT_RGB30: begin
            r.chan0 = 16'(w[9:0]);
            r.chan1 = 16'(w[19:10]);
            r.chan2 = 16'(w[29:20]);
         end
         FMT_MONO12: begin
            r.chan0 = k[0] ? 16'({b[2], b[1][3:0]}) : 16'({b[0], b[1][7:4]});
         end
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/core/packed_pixel_format_unpacker.sv
// Packed pixel format unpacker, top level.
// The req channel takes one raw stream byte per transaction, with
// req_start_req marking the first byte of a frame. Once a group of bytes is
// complete for the selected format, the rsp channel delivers one to eight
// pixels as separate transactions, rsp_last set on the group's final pixel.
// Throughput: one byte per cycle in while req_stall is low, one pixel per
// cycle out while rsp_stall is low. A group's first pixel passes through the
// queue and the output register; the single pixel generator walks the group.
// A two-group queue sits between byte collection and pixel generation.
// req_stall rises only when that queue holds two groups, so a stall on rsp
// backs up into the queue before it reaches the byte side.
// The csr port writes format, luma_offset, plane mapping, byte_swap and
// sample_mask; index 7 is ignored. Write only while the block is idle.
// Reset clears the group phase, empties the queue and the output register,
// and returns all configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_pixel_format_unpacker_assert.svh"
module packed_pixel_format_unpacker
   import ppfu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [2:0]          csr_index,
   input  wire logic [CsrWidth-1:0] csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_start_req,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [15:0]              rsp_chan0,
   output logic [15:0]              rsp_chan1,
   output logic [15:0]              rsp_chan2,
   output logic                     rsp_last
);

   unpack_cfg_type cfg_ff, cfg_in;
   logic      push;
   group_type push_group;
   logic      queue_full;
   logic      queue_empty;
   logic      pop;
   group_type head_group;
   logic      fmt_known;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FORMAT:      cfg_in.format      = csr_write_data[3:0];
            CSR_LUMA_OFFSET: cfg_in.luma_offset = csr_write_data[0];
            CSR_RED_PLANE:   cfg_in.red_plane   = csr_write_data[1:0];
            CSR_GREEN_PLANE: cfg_in.green_plane = csr_write_data[1:0];
            CSR_BLUE_PLANE:  cfg_in.blue_plane  = csr_write_data[1:0];
            CSR_BYTE_SWAP:   cfg_in.byte_swap   = csr_write_data[0];
            CSR_SAMPLE_MASK: cfg_in.sample_mask = csr_write_data[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format      <= FMT_YUYV8;
         cfg_ff.luma_offset <= 1'b0;
         cfg_ff.red_plane   <= 2'd0;
         cfg_ff.green_plane <= 2'd1;
         cfg_ff.blue_plane  <= 2'd2;
         cfg_ff.byte_swap   <= 1'b0;
         cfg_ff.sample_mask <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppfu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .format        (cfg_ff.format),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_start_req (req_start_req),
      .queue_full    (queue_full),
      .push          (push),
      .push_group    (push_group)
   );

   ppfu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head_group (head_group)
   );

   ppfu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head_group  (head_group),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_chan0   (rsp_chan0),
      .rsp_chan1   (rsp_chan1),
      .rsp_chan2   (rsp_chan2),
      .rsp_last    (rsp_last)
   );

   assign fmt_known = (fmt_group_size(cfg_ff.format) != 4'd0);

   `PPFU_ASSERT_NOW(a_push_not_full, clock, reset, push, !queue_full, "push into full queue")
   `PPFU_ASSERT_NOW(a_push_known_fmt, clock, reset, push, fmt_known, "push for unused format")
   `PPFU_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall, "reset not idle")

endmodule
`default_nettype wire

### rtl/core/ppfu_queue.sv
// two-entry group queue between the byte collector and the pixel generator
`timescale 1ns / 1ps
`default_nettype none
module ppfu_queue
   import ppfu_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire group_type push_group,
   output logic           full,
   input  wire logic      pop,
   output logic           empty,
   output group_type      head_group
);

   group_type  entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign empty      = (count_ff == 2'd0);
   assign head_group = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule
`default_nettype wire

### rtl/core/ppfu_front.sv
// byte collector: tracks group phase and hands complete groups to the queue
`timescale 1ns / 1ps
`default_nettype none
module ppfu_front
   import ppfu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [3:0] format,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_start_req,
   input  wire logic       queue_full,
   output logic            push,
   output group_type       push_group
);

   logic [3:0] phase_ff, phase_in;
   group_type  bytes_ff, bytes_in;
   logic       accept;
   logic [3:0] size;
   logic [3:0] slot;
   logic [4:0] next_phase;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign size      = fmt_group_size(format);

   always_comb begin
      slot = req_start_req ? 4'd0 : phase_ff;
      if (slot > 4'd11) begin
         slot = 4'd0;
      end
      next_phase = {1'b0, slot} + 5'd1;
      bytes_in   = bytes_ff;
      bytes_in[slot] = req_data_byte;
      push       = 1'b0;
      phase_in   = phase_ff;
      if (accept) begin
         if (size == 4'd0) begin
            phase_in = 4'd0;
         end else if (next_phase >= {1'b0, size}) begin
            push     = 1'b1;
            phase_in = 4'd0;
         end else begin
            phase_in = next_phase[3:0];
         end
      end
   end

   assign push_group = bytes_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && size != 4'd0) begin
         bytes_ff <= bytes_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/ppfu_back.sv
// pixel generator: walks each queued group and drives the output register
`timescale 1ns / 1ps
`default_nettype none
module ppfu_back
   import ppfu_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire unpack_cfg_type cfg,
   input  wire logic           queue_empty,
   input  wire group_type      head_group,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic [15:0]         rsp_chan0,
   output logic [15:0]         rsp_chan1,
   output logic [15:0]         rsp_chan2,
   output logic                rsp_last
);

   logic [2:0] pix_idx_ff, pix_idx_in;
   logic       valid_ff, valid_in;
   pixel_type  pix_ff, pix_in;
   logic       last_ff, last_in;
   logic       load;
   logic       is_last;

   assign load    = !valid_ff || !rsp_stall;
   assign is_last = (pix_idx_ff == fmt_last_pixel(cfg.format));

   always_comb begin
      pix_in     = unpack_pixel(cfg, pix_idx_ff, head_group);
      last_in    = is_last;
      valid_in   = valid_ff;
      pix_idx_in = pix_idx_ff;
      pop        = 1'b0;
      if (load) begin
         valid_in = !queue_empty;
         if (!queue_empty) begin
            if (is_last) begin
               pop        = 1'b1;
               pix_idx_in = 3'd0;
            end else begin
               pix_idx_in = pix_idx_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pix_idx_ff <= 3'd0;
      end else begin
         valid_ff   <= valid_in;
         pix_idx_ff <= pix_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !queue_empty) begin
         pix_ff  <= pix_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_chan0 = pix_ff.chan0;
   assign rsp_chan1 = pix_ff.chan1;
   assign rsp_chan2 = pix_ff.chan2;
   assign rsp_last  = last_ff;

endmodule
`default_nettype wire

### test/tb_top.sv
// self-checking testbench for the packed pixel format unpacker
`timescale 1ns / 1ps
module tb_top;
   import ppfu_pkg::*;

   localparam logic [3:0] FMT_SPARE14  = 4'd14;
   localparam logic [3:0] FMT_SPARE15  = 4'd15;
   localparam logic [2:0] CSR_SPARE    = 3'd7;
   localparam int         RANDOM_ITEMS = 360;
   localparam int         QUIET_ITEMS  = 60;
   localparam int         SETTLE_CYCLES = 12;
   localparam int         HOLD_CYCLES  = 150;
   localparam int         CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [15:0] c0;
      logic [15:0] c1;
      logic [15:0] c2;
      logic        last;
   } pixel_rec;

   typedef struct packed {
      logic [2:0]  cfg_sel;
      logic [7:0]  data;
      logic        start;
      logic        known;
      logic [15:0] e0;
      logic [15:0] e1;
      logic [15:0] e2;
   } stim_row;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [2:0]          csr_index = CSR_FORMAT;
   logic [CsrWidth-1:0] csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_data_byte = 8'h00;
   logic                req_start_req = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [15:0]         rsp_chan0;
   logic [15:0]         rsp_chan1;
   logic [15:0]         rsp_chan2;
   logic                rsp_last;

   // shadow of the block: configuration, byte store and group phase
   unpack_cfg_type shadow_cfg = '{FMT_YUYV8, 1'b0, 2'd0, 2'd1, 2'd2, 1'b0, 16'hFFFF};
   logic [7:0]     grp [12] = '{default: 8'h00};
   int             grp_phase = 0;
   pixel_rec       fresh_pix [8];
   pixel_rec       pixels_due [$];

   int mismatches = 0;
   int cycle_count = 0;
   int req_odds = 0;
   int rsp_odds = 0;
   bit quiet = 1'b0;
   int hold_requests = 0;

   stim_row        directed_rows [27];
   unpack_cfg_type directed_cfgs [8];

   packed_pixel_format_unpacker dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_start_req    (req_start_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_chan0        (rsp_chan0),
      .rsp_chan1        (rsp_chan1),
      .rsp_chan2        (rsp_chan2),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("packed_pixel_format_unpacker verification failed");
         $finish;
      end
   end

   function automatic int group_len(input logic [3:0] f);
      case (f)
         FMT_YUYV8:  return 4;
         FMT_YUYV16: return 8;
         FMT_UYYVYY: return 6;
         FMT_YUV41P: return 12;
         FMT_BGR15, FMT_BGR15X, FMT_BGR16, FMT_BGR16X: return 2;
         FMT_RGB24:  return 3;
         FMT_ARGB32, FMT_BGRA32, FMT_RGB30: return 4;
         FMT_RGB48:  return 6;
         FMT_MONO12: return 3;
         default:    return 0;
      endcase
   endfunction

   function automatic logic [15:0] grp_word(input int i);
      return {grp[i+1], grp[i]};
   endfunction

   function automatic void set_pix(input int k, input logic [15:0] a, input logic [15:0] b,
                                   input logic [15:0] c);
      fresh_pix[k] = {a, b, c, 1'b0};
   endfunction

   function automatic void shadow_write(input logic [2:0] idx, input logic [15:0] val);
      case (idx)
         CSR_FORMAT:      shadow_cfg.format = val[3:0];
         CSR_LUMA_OFFSET: shadow_cfg.luma_offset = val[0];
         CSR_RED_PLANE:   shadow_cfg.red_plane = val[1:0];
         CSR_GREEN_PLANE: shadow_cfg.green_plane = val[1:0];
         CSR_BLUE_PLANE:  shadow_cfg.blue_plane = val[1:0];
         CSR_BYTE_SWAP:   shadow_cfg.byte_swap = val[0];
         CSR_SAMPLE_MASK: shadow_cfg.sample_mask = val;
         default: ;
      endcase
   endfunction

   // takes one stream byte; returns how many pixels the byte releases into fresh_pix
   function automatic int absorb_byte(input logic [7:0] d, input logic s);
      int          len;
      int          n;
      int          yo;
      int          i;
      int          b0;
      int          b1;
      logic [15:0] u;
      logic [15:0] v;
      logic [15:0] w;
      logic [31:0] w32;
      logic [15:0] smp [3];
      logic [15:0] ch [4];
      if (s) grp_phase = 0;
      len = group_len(shadow_cfg.format);
      if (len == 0) begin
         grp_phase = 0;
         return 0;
      end
      if (grp_phase > 11) grp_phase = 0;
      grp[grp_phase] = d;
      grp_phase++;
      if (grp_phase < len) return 0;
      grp_phase = 0;
      yo = shadow_cfg.luma_offset;
      b0 = grp[0];
      b1 = grp[1];
      n = 1;
      case (shadow_cfg.format)
         FMT_YUYV8: begin
            u = grp[1 - yo];
            v = grp[3 - yo];
            set_pix(0, grp[yo], u, v);
            set_pix(1, grp[2 + yo], u, v);
            n = 2;
         end
         FMT_YUYV16: begin
            u = grp_word(2 * (1 - yo));
            v = grp_word(2 * (3 - yo));
            set_pix(0, grp_word(2 * yo), u, v);
            set_pix(1, grp_word(2 * (2 + yo)), u, v);
            n = 2;
         end
         FMT_UYYVYY: begin
            set_pix(0, grp[1], grp[0], grp[3]);
            set_pix(1, grp[2], grp[0], grp[3]);
            set_pix(2, grp[4], grp[0], grp[3]);
            set_pix(3, grp[5], grp[0], grp[3]);
            n = 4;
         end
         FMT_YUV41P: begin
            for (i = 0; i < 4; i++) begin
               set_pix(i, grp[2 * i + 1], grp[0], grp[2]);
               set_pix(4 + i, grp[8 + i], grp[4], grp[6]);
            end
            n = 8;
         end
         FMT_BGR15:
            set_pix(0, (b1 & 'h7C) << 1, ((b0 >> 5) + ((b1 & 'h3) << 3)) << 3, (b0 << 3) & 'hFF);
         FMT_BGR15X: begin
            set_pix(0, (b0 & 'h7C) << 1, ((b1 >> 5) + ((b0 & 'h3) << 3)) << 3,
                    (b1 & 'h1F) << 3);
         end
         FMT_BGR16:
            set_pix(0, b1 & 'hF8, ((b0 >> 5) + ((b1 & 'h7) << 3)) << 2, (b0 << 3) & 'hFF);
         FMT_BGR16X:
            set_pix(0, b0 & 'hF8, ((b1 >> 5) + ((b0 & 'h7) << 3)) << 2, (b1 & 'h1F) << 3);
         FMT_ARGB32: set_pix(0, grp[1], grp[2], grp[3]);
         FMT_BGRA32: set_pix(0, grp[2], grp[1], grp[0]);
         FMT_RGB24, FMT_RGB48: begin
            for (i = 0; i < 3; i++) begin
               if (shadow_cfg.format == FMT_RGB24) begin
                  smp[i] = grp[i];
               end else begin
                  w = grp_word(2 * i);
                  if (shadow_cfg.byte_swap) w = {w[7:0], w[15:8]};
                  smp[i] = w & shadow_cfg.sample_mask;
               end
            end
            ch = '{default: 16'h0000};
            ch[shadow_cfg.red_plane] = smp[0];
            ch[shadow_cfg.green_plane] = smp[1];
            ch[shadow_cfg.blue_plane] = smp[2];
            set_pix(0, ch[0], ch[1], ch[2]);
         end
         FMT_RGB30: begin
            w32 = {grp[3], grp[2], grp[1], grp[0]};
            set_pix(0, w32 & 'h3FF, (w32 >> 10) & 'h3FF, (w32 >> 20) & 'h3FF);
         end
         FMT_MONO12: begin
            set_pix(0, (b0 << 4) + (b1 >> 4), 0, 0);
            set_pix(1, (b1 & 'hF) + (int'(grp[2]) << 4), 0, 0);
            n = 2;
         end
         default: n = 0;
      endcase
      if (n > 0) fresh_pix[n-1].last = 1'b1;
      return n;
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic take_pixel();
      pixel_rec want;
      if (pixels_due.size() == 0) begin
         $display("%0t: unexpected pixel %h %h %h last %b", $time, rsp_chan0, rsp_chan1,
                  rsp_chan2, rsp_last);
         mismatches++;
      end else begin
         want = pixels_due.pop_front();
         compare_field("chan0", want.c0, rsp_chan0);
         compare_field("chan1", want.c1, rsp_chan1);
         compare_field("chan2", want.c2, rsp_chan2);
         compare_field("last", 16'(want.last), 16'(rsp_last));
      end
   endtask

   // pixel side: checks each transaction and drives stall bursts and the long hold
   initial begin : pixel_side
      int burst;
      int hold;
      int served;
      burst = 0;
      hold = 0;
      served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) take_pixel();
         if (hold_requests != served) begin
            served++;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet && rsp_odds != 0 && $urandom_range(0, rsp_odds - 1) == 0) begin
            burst = $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic s, input logic known,
                            input pixel_rec typed_pix);
      int n;
      int i;
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_start_req <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n = absorb_byte(d, s);
      for (i = 0; i < n; i++) pixels_due.push_back(known ? typed_pix : fresh_pix[i]);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_setting(input unpack_cfg_type c);
      logic [15:0] junk;
      logic [15:0] val [8];
      logic [2:0]  idx [8];
      int          i;
      junk = 16'($urandom);
      idx = '{CSR_FORMAT, CSR_LUMA_OFFSET, CSR_RED_PLANE, CSR_GREEN_PLANE, CSR_BLUE_PLANE,
              CSR_BYTE_SWAP, CSR_SAMPLE_MASK, CSR_SPARE};
      val = '{{junk[15:4], c.format}, {junk[15:1], c.luma_offset},
              {junk[15:2], c.red_plane}, {junk[15:2], c.green_plane},
              {junk[15:2], c.blue_plane}, {junk[15:1], c.byte_swap}, c.sample_mask, junk};
      for (i = 0; i < 8; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_write_data <= val[i];
         @(posedge clock);
         shadow_write(idx[i], val[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic unpack_cfg_type random_setting();
      unpack_cfg_type c;
      int             p;
      c.format = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(14, 15))
                                              : 4'($urandom_range(0, 13));
      c.luma_offset = 1'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         c.red_plane = 2'($urandom);
         c.green_plane = 2'($urandom);
         c.blue_plane = 2'($urandom);
      end else begin
         p = $urandom_range(0, 2);
         c.red_plane = 2'(p);
         c.green_plane = 2'((p + 1 + $urandom_range(0, 1)) % 3);
         c.blue_plane = 2'(3 - p - c.green_plane);
      end
      c.byte_swap = 1'($urandom);
      case ($urandom_range(0, 3))
         0:       c.sample_mask = 16'h0000;
         1:       c.sample_mask = 16'hFFFF;
         default: c.sample_mask = 16'($urandom);
      endcase
      return c;
   endfunction

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin : byte_side
      int             prev_sel;
      int             r;
      int             k;
      int             len;
      int             size;
      int             counted;
      bit             pressure_done;
      logic           s;
      unpack_cfg_type c;
      directed_cfgs = '{
         '{FMT_BGR16,   1'b0, 2'd0, 2'd1, 2'd2, 1'b0, 16'hFFFF},
         '{FMT_BGR15X,  1'b0, 2'd0, 2'd1, 2'd2, 1'b0, 16'hFFFF},
         '{FMT_RGB30,   1'b0, 2'd0, 2'd1, 2'd2, 1'b0, 16'hFFFF},
         '{FMT_RGB48,   1'b1, PLANE_NONE, 2'd0, 2'd0, 1'b1, 16'h0FF0},
         '{FMT_SPARE14, 1'b0, 2'd0, 2'd1, 2'd2, 1'b0, 16'h0000},
         '{FMT_SPARE15, 1'b1, 2'd2, 2'd2, 2'd2, 1'b1, 16'hFFFF},
         '{FMT_YUV41P,  1'b0, 2'd0, 2'd1, 2'd2, 1'b0, 16'hFFFF},
         '{FMT_RGB24,   1'b0, 2'd2, 2'd1, 2'd0, 1'b0, 16'hFFFF}
      };
      directed_rows = '{
         '{3'd0, 8'hFF, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd0, 8'hFF, 1'b0, 1'b1, 16'h00F8, 16'h00FC, 16'h00F8},
         '{3'd0, 8'h00, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd0, 8'h00, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000},
         '{3'd1, 8'h7C, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd1, 8'h00, 1'b0, 1'b1, 16'h00F8, 16'h0000, 16'h0000},
         '{3'd2, 8'hFF, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd2, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd2, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd2, 8'hFF, 1'b0, 1'b1, 16'h03FF, 16'h03FF, 16'h03FF},
         '{3'd3, 8'h01, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd3, 8'h02, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd3, 8'h03, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd3, 8'h04, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd3, 8'h05, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd3, 8'h06, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd4, 8'h12, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd4, 8'h34, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd5, 8'h56, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd6, 8'hAA, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd6, 8'hBB, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd6, 8'hCC, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd6, 8'h11, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd6, 8'h22, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd6, 8'h33, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd6, 8'h44, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
         '{3'd7, 8'h55, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed rows; the last one lands mid-group after a format change
      prev_sel = -1;
      rsp_odds = 4;
      for (r = 0; r < 27; r++) begin
         if (directed_rows[r].cfg_sel != prev_sel) begin
            settle();
            load_setting(directed_cfgs[directed_rows[r].cfg_sel]);
            prev_sel = directed_rows[r].cfg_sel;
         end
         send_byte(directed_rows[r].data, directed_rows[r].start, directed_rows[r].known,
                   {directed_rows[r].e0, directed_rows[r].e1, directed_rows[r].e2, 1'b1});
      end

      // random phases, the first one backs up behind a long pixel-side hold
      counted = 0;
      pressure_done = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         settle();
         if (!pressure_done) c = '{FMT_YUYV8, 1'b1, 2'd0, 2'd1, 2'd2, 1'b0, 16'hFFFF};
         else c = random_setting();
         load_setting(c);
         req_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
         rsp_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
         size = group_len(c.format);
         if (size == 0) len = $urandom_range(1, 4);
         else len = size * $urandom_range(1, 5)
                    + (($urandom_range(0, 3) == 0) ? $urandom_range(1, size - 1) : 0);
         if (!pressure_done) begin
            hold_requests <= hold_requests + 1;
            req_odds = 0;
            len = 64;
         end
         for (k = 0; k < len; k++) begin
            s = (k == 0) ? 1'($urandom) : ($urandom_range(0, 39) == 0);
            send_byte(random_byte(), s, 1'b0, '0);
            if (size != 0) counted++;
            quiet = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
            if (!quiet && req_odds != 0 && $urandom_range(0, req_odds - 1) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         pressure_done = 1'b1;
      end

      settle();
      if (mismatches == 0 && pixels_due.size() == 0) begin
         $display("packed_pixel_format_unpacker verification clean");
      end else begin
         $display("packed_pixel_format_unpacker verification failed");
      end
      $finish;
   end

endmodule
